// ----- rtl/core/clqm_pkg.sv -----
// Shared types and constants for the circular linked queue manager.
// Holds transfer structs, status and action codes, and the microcode store.
// No dependencies.
package clqm_pkg;

	localparam int ID_W  = 4;
	localparam int ID_N  = 1 << ID_W;
	localparam int CNT_W = 5;
	localparam int UPC_W = 3;

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_TEST   = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_EMPTY      = 2'd1;
	localparam logic [1:0] ST_NOT_MEMBER = 2'd2;
	localparam logic [1:0] ST_LINKED     = 2'd3;

	typedef struct packed {
		logic [1:0]      action;
		logic [ID_W-1:0] element_id;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             found;
		logic [CNT_W-1:0] occupancy;
		logic [ID_W-1:0]  head_id;
	} rsp_t;

	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_WR_SELF,
		OP_RD_HEAD,
		OP_LINK_TAIL,
		OP_CLOSE_NEW,
		OP_DROP_LAST,
		OP_RD_ID,
		OP_UNLINK
	} dp_op_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_JUMP,
		SEQ_END
	} seq_t;

	typedef struct packed {
		dp_op_t op;
		seq_t   seq;
		upc_t   target;
	} uword_t;

	typedef struct packed {
		logic   busy;
		uword_t uword;
	} ctrl_t;

	// entry points
	localparam upc_t UPC_APP_EMPTY = 3'd0;
	localparam upc_t UPC_APP_TAIL  = 3'd1;
	localparam upc_t UPC_APP_LINK  = 3'd2;
	localparam upc_t UPC_APP_CLOSE = 3'd3;
	localparam upc_t UPC_REM_LAST  = 3'd4;
	localparam upc_t UPC_REM_MID   = 3'd5;
	localparam upc_t UPC_UNLINK    = 3'd6;
	localparam upc_t UPC_RESPOND   = 3'd7;

	function automatic uword_t ucode_rom(input upc_t upc);
		uword_t w;
		begin
			case (upc)
				UPC_APP_EMPTY: w = '{op: OP_WR_SELF,   seq: SEQ_JUMP, target: UPC_RESPOND};
				UPC_APP_TAIL:  w = '{op: OP_RD_HEAD,   seq: SEQ_NEXT, target: UPC_RESPOND};
				UPC_APP_LINK:  w = '{op: OP_LINK_TAIL, seq: SEQ_NEXT, target: UPC_RESPOND};
				UPC_APP_CLOSE: w = '{op: OP_CLOSE_NEW, seq: SEQ_JUMP, target: UPC_RESPOND};
				UPC_REM_LAST:  w = '{op: OP_DROP_LAST, seq: SEQ_JUMP, target: UPC_RESPOND};
				UPC_REM_MID:   w = '{op: OP_RD_ID,     seq: SEQ_NEXT, target: UPC_RESPOND};
				UPC_UNLINK:    w = '{op: OP_UNLINK,    seq: SEQ_NEXT, target: UPC_RESPOND};
				UPC_RESPOND:   w = '{op: OP_NONE,      seq: SEQ_END,  target: UPC_RESPOND};
				default:       w = '{op: OP_NONE,      seq: SEQ_END,  target: UPC_RESPOND};
			endcase
			return w;
		end
	endfunction

endpackage

// ----- rtl/core/clqm_ram.sv -----
// Generic single write port RAM with one registered read port.
// No dependencies.
module clqm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/clqm_seq.sv -----
// Microcode sequencer: step counter, busy flag and control store lookup.
// Depends on clqm_pkg.
module clqm_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  clqm_pkg::upc_t      entry,
	input  logic                out_free,
	output clqm_pkg::ctrl_t     ctrl
);

	logic              busy_q;
	clqm_pkg::upc_t    upc_q;
	clqm_pkg::uword_t  uword;

	assign uword      = clqm_pkg::ucode_rom(upc_q);
	assign ctrl.busy  = busy_q;
	assign ctrl.uword = uword;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= clqm_pkg::UPC_RESPOND;
		end else if (start) begin
			busy_q <= 1'b1;
			upc_q  <= entry;
		end else if (busy_q) begin
			case (uword.seq)
				clqm_pkg::SEQ_NEXT: begin
					upc_q <= upc_q + clqm_pkg::upc_t'(1);
				end
				clqm_pkg::SEQ_JUMP: begin
					upc_q <= uword.target;
				end
				clqm_pkg::SEQ_END: begin
					if (out_free) begin
						busy_q <= 1'b0;
					end
				end
				default: begin
					busy_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/circular_linked_queue_manager.sv -----
// Circular doubly linked queue manager, top level.
// Depends on clqm_pkg, clqm_seq and clqm_ram.
//
//   channel | signals                     | moves
//   req     | req_valid, req_stall, req   | one action on one element id
//   rsp     | rsp_valid, rsp_stall, rsp   | status, found, size and head
//
// One item at a time. After the accepting edge the microcode runs: append to a
// nonempty queue reads the head's prev link, links the tail, closes the ring;
// remove of an inner member reads its links, then unlinks; an empty append
// writes self links, a last remove drops it. The result lands in an output register;
// req_stall stays high until it does. A stalled rsp holds the last step.
// Reset clears member flags, head, count and control; link RAMs are not cleared.
module circular_linked_queue_manager #(
	parameter int POOL_SIZE = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  clqm_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output clqm_pkg::rsp_t  rsp
);

	localparam int MEM_N = (POOL_SIZE < clqm_pkg::ID_N) ? POOL_SIZE : clqm_pkg::ID_N;
	localparam int IDX_W = (MEM_N > 1) ? $clog2(MEM_N) : 1;
	localparam int CW    = clqm_pkg::CNT_W;

	clqm_pkg::ctrl_t  ctrl;
	logic             accept;
	logic             out_free;
	logic             finish;
	clqm_pkg::upc_t   entry;

	logic [IDX_W-1:0] req_idx;
	logic             in_pool;
	logic             is_mem;
	logic [1:0]       status_d;
	logic             found_d;

	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CW-1:0]    count_q;
	logic [MEM_N-1:0] flag_q;
	logic [1:0]       status_q;
	logic             found_q;
	logic             rsp_valid_q;
	clqm_pkg::rsp_t   rsp_q;

	logic             nx_we, pv_we;
	logic [IDX_W-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata;
	logic [IDX_W-1:0] nx_raddr, pv_raddr;
	logic [IDX_W-1:0] nx_rdata, pv_rdata;

	assign req_stall = ctrl.busy;
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign finish    = ctrl.busy && (ctrl.uword.seq == clqm_pkg::SEQ_END) && out_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign req_idx = IDX_W'(req.element_id);
	assign in_pool = 32'(req.element_id) < POOL_SIZE;
	assign is_mem  = in_pool && flag_q[req_idx];

	// classify the item and preset its status
	always_comb begin
		status_d = clqm_pkg::ST_OK;
		found_d  = 1'b0;
		entry    = clqm_pkg::UPC_RESPOND;
		case (req.action)
			clqm_pkg::ACT_APPEND: begin
				if (!in_pool) begin
					status_d = clqm_pkg::ST_NOT_MEMBER;
				end else if (is_mem) begin
					status_d = clqm_pkg::ST_LINKED;
				end else if (count_q == '0) begin
					entry = clqm_pkg::UPC_APP_EMPTY;
				end else begin
					entry = clqm_pkg::UPC_APP_TAIL;
				end
			end
			clqm_pkg::ACT_REMOVE: begin
				if (count_q == '0) begin
					status_d = clqm_pkg::ST_EMPTY;
				end else if (!is_mem) begin
					status_d = clqm_pkg::ST_NOT_MEMBER;
				end else if (count_q == CW'(1)) begin
					entry = clqm_pkg::UPC_REM_LAST;
				end else begin
					entry = clqm_pkg::UPC_REM_MID;
				end
			end
			clqm_pkg::ACT_TEST: begin
				if (count_q == '0) begin
					status_d = clqm_pkg::ST_EMPTY;
				end else begin
					found_d = is_mem;
				end
			end
			default: begin
				status_d = clqm_pkg::ST_OK;
			end
		endcase
	end

	clqm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.entry    (entry),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	// link RAM ports
	always_comb begin
		nx_we    = 1'b0;
		pv_we    = 1'b0;
		nx_waddr = idx_q;
		nx_wdata = idx_q;
		pv_waddr = idx_q;
		pv_wdata = idx_q;
		nx_raddr = idx_q;
		pv_raddr = idx_q;
		if (ctrl.busy) begin
			case (ctrl.uword.op)
				clqm_pkg::OP_WR_SELF: begin
					nx_we = 1'b1;
					pv_we = 1'b1;
				end
				clqm_pkg::OP_RD_HEAD: begin
					pv_raddr = head_q;
				end
				clqm_pkg::OP_LINK_TAIL: begin
					nx_we    = 1'b1;
					nx_waddr = pv_rdata;
					pv_we    = 1'b1;
					pv_waddr = head_q;
				end
				clqm_pkg::OP_CLOSE_NEW: begin
					nx_we    = 1'b1;
					nx_wdata = head_q;
					pv_we    = 1'b1;
					pv_wdata = tail_q;
				end
				clqm_pkg::OP_UNLINK: begin
					nx_we    = 1'b1;
					nx_waddr = pv_rdata;
					nx_wdata = nx_rdata;
					pv_we    = 1'b1;
					pv_waddr = nx_rdata;
					pv_wdata = pv_rdata;
				end
				default: begin
					nx_we = 1'b0;
				end
			endcase
		end
	end

	clqm_ram #(.WIDTH(IDX_W), .DEPTH(MEM_N)) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (nx_raddr),
		.rdata (nx_rdata)
	);

	clqm_ram #(.WIDTH(IDX_W), .DEPTH(MEM_N)) u_prev_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.raddr (pv_raddr),
		.rdata (pv_rdata)
	);

	// item registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q    <= req_idx;
			status_q <= status_d;
			found_q  <= found_d;
		end
		if (ctrl.busy && (ctrl.uword.op == clqm_pkg::OP_LINK_TAIL)) begin
			tail_q <= pv_rdata;
		end
		if (finish) begin
			rsp_q.status    <= status_q;
			rsp_q.found     <= found_q;
			rsp_q.occupancy <= count_q;
			rsp_q.head_id   <= (count_q == '0) ? '0 : clqm_pkg::ID_W'(head_q);
		end
	end

	// queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			flag_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctrl.busy) begin
				case (ctrl.uword.op)
					clqm_pkg::OP_WR_SELF: begin
						head_q        <= idx_q;
						flag_q[idx_q] <= 1'b1;
						count_q       <= count_q + CW'(1);
					end
					clqm_pkg::OP_CLOSE_NEW: begin
						flag_q[idx_q] <= 1'b1;
						count_q       <= count_q + CW'(1);
					end
					clqm_pkg::OP_DROP_LAST: begin
						head_q        <= '0;
						flag_q[idx_q] <= 1'b0;
						count_q       <= '0;
					end
					clqm_pkg::OP_UNLINK: begin
						if (head_q == idx_q) begin
							head_q <= nx_rdata;
						end
						flag_q[idx_q] <= 1'b0;
						count_q       <= count_q - CW'(1);
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- tb/tb_circular_linked_queue_manager.sv -----
// Self-checking testbench for circular_linked_queue_manager: directed table, then random
// fill/drain traffic with sender gaps and receiver stalls, checked against a queue predictor.
// Depends on clqm_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_circular_linked_queue_manager;

	localparam logic [1:0] ACT_NOP = 2'd3;
	localparam int NDIR = 23;
	localparam int NRAND = 1300;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		clqm_pkg::req_t r;
		logic fixed;
		clqm_pkg::rsp_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	clqm_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	clqm_pkg::rsp_t rsp;

	logic item_fixed = 1'b0;
	clqm_pkg::rsp_t item_want = '0;
	int send_gap_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int quiet = 0;
	clqm_pkg::rsp_t expect_q [$];

	logic [clqm_pkg::ID_W-1:0] link_fwd [clqm_pkg::ID_N];
	logic [clqm_pkg::ID_W-1:0] link_back [clqm_pkg::ID_N];
	bit on_list [clqm_pkg::ID_N];
	logic [clqm_pkg::ID_W-1:0] front_id = '0;
	logic [clqm_pkg::CNT_W-1:0] depth = '0;

	row_t plan [NDIR];

	circular_linked_queue_manager i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic clqm_pkg::rsp_t advance_queue(input clqm_pkg::req_t r);
		clqm_pkg::rsp_t o;
		logic [clqm_pkg::ID_W-1:0] id;
		logic [clqm_pkg::ID_W-1:0] tail;
		logic [clqm_pkg::ID_W-1:0] after;
		logic [clqm_pkg::ID_W-1:0] ahead;
		o = '0;
		o.status = clqm_pkg::ST_OK;
		id = r.element_id;
		case (r.action)
			clqm_pkg::ACT_APPEND: begin
				if (on_list[id]) begin
					o.status = clqm_pkg::ST_LINKED;
				end else begin
					if (depth == 0) begin
						front_id = id;
						link_fwd[id] = id;
						link_back[id] = id;
					end else begin
						tail = link_back[front_id];
						link_fwd[tail] = id;
						link_back[front_id] = id;
						link_back[id] = tail;
						link_fwd[id] = front_id;
					end
					on_list[id] = 1'b1;
					depth = depth + 1'b1;
				end
			end
			clqm_pkg::ACT_REMOVE: begin
				if (depth == 0) begin
					o.status = clqm_pkg::ST_EMPTY;
				end else if (!on_list[id]) begin
					o.status = clqm_pkg::ST_NOT_MEMBER;
				end else begin
					on_list[id] = 1'b0;
					if (depth == 1) begin
						depth = '0;
						front_id = '0;
					end else begin
						after = link_fwd[id];
						ahead = link_back[id];
						if (front_id == id)
							front_id = after;
						link_fwd[ahead] = after;
						link_back[after] = ahead;
						depth = depth - 1'b1;
					end
				end
			end
			clqm_pkg::ACT_TEST: begin
				if (depth == 0)
					o.status = clqm_pkg::ST_EMPTY;
				else
					o.found = on_list[id];
			end
			default: ;
		endcase
		o.occupancy = depth;
		o.head_id = (depth == 0) ? '0 : front_id;
		return o;
	endfunction

	function automatic clqm_pkg::req_t draw_item(input bit filling);
		clqm_pkg::req_t r;
		int roll;
		logic [clqm_pkg::ID_W-1:0] held [$];
		logic [clqm_pkg::ID_W-1:0] spare [$];
		for (int k = 0; k < clqm_pkg::ID_N; k++) begin
			if (on_list[k])
				held.push_back(clqm_pkg::ID_W'(k));
			else
				spare.push_back(clqm_pkg::ID_W'(k));
		end
		r.element_id = clqm_pkg::ID_W'($urandom_range(clqm_pkg::ID_N - 1));
		roll = $urandom_range(99);
		if (roll < 4)
			r.action = ACT_NOP;
		else if (roll < (filling ? 70 : 22))
			r.action = clqm_pkg::ACT_APPEND;
		else if (roll < 84)
			r.action = clqm_pkg::ACT_REMOVE;
		else
			r.action = clqm_pkg::ACT_TEST;
		roll = $urandom_range(99);
		if (r.action == clqm_pkg::ACT_APPEND && roll < 80 && spare.size() != 0)
			r.element_id = spare[$urandom_range(spare.size() - 1)];
		else if (r.action != clqm_pkg::ACT_APPEND && roll < 75 && held.size() != 0)
			r.element_id = held[$urandom_range(held.size() - 1)];
		return r;
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(input clqm_pkg::req_t r, input logic fixed,
			input clqm_pkg::rsp_t want);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		item_fixed <= fixed;
		item_want <= want;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : scoreboard
		clqm_pkg::rsp_t pred;
		clqm_pkg::rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				pred = advance_queue(req);
				expect_q.push_back(item_fixed ? item_want : pred);
			end
			if (rsp_valid && !rsp_stall) begin
				if (expect_q.size() == 0) begin
					note_mismatch("result with none pending, status", int'(rsp.status), 0);
				end else begin
					want = expect_q.pop_front();
					if (rsp.status !== want.status)
						note_mismatch("status", int'(rsp.status), int'(want.status));
					if (rsp.found !== want.found)
						note_mismatch("found", int'(rsp.found), int'(want.found));
					if (rsp.occupancy !== want.occupancy)
						note_mismatch("occupancy", int'(rsp.occupancy),
							int'(want.occupancy));
					if (rsp.head_id !== want.head_id)
						note_mismatch("head_id", int'(rsp.head_id), int'(want.head_id));
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		bit filling;
		clqm_pkg::req_t r;
		int phase;
		for (int k = 0; k < clqm_pkg::ID_N; k++) begin
			link_fwd[k] = '0;
			link_back[k] = '0;
		end
		plan = '{
			'{'{clqm_pkg::ACT_TEST,   4'd0},  1'b1, '{clqm_pkg::ST_EMPTY, 1'b0, 5'd0, 4'd0}},
			'{'{clqm_pkg::ACT_REMOVE, 4'd15}, 1'b1, '{clqm_pkg::ST_EMPTY, 1'b0, 5'd0, 4'd0}},
			'{'{ACT_NOP,              4'd15}, 1'b1, '{clqm_pkg::ST_OK,    1'b0, 5'd0, 4'd0}},
			'{'{clqm_pkg::ACT_APPEND, 4'd0},  1'b1, '{clqm_pkg::ST_OK,    1'b0, 5'd1, 4'd0}},
			'{'{clqm_pkg::ACT_APPEND, 4'd0},  1'b1, '{clqm_pkg::ST_LINKED, 1'b0, 5'd1, 4'd0}},
			'{'{clqm_pkg::ACT_TEST,   4'd0},  1'b1, '{clqm_pkg::ST_OK,    1'b1, 5'd1, 4'd0}},
			'{'{clqm_pkg::ACT_REMOVE, 4'd0},  1'b1, '{clqm_pkg::ST_OK,    1'b0, 5'd0, 4'd0}},
			'{'{clqm_pkg::ACT_APPEND, 4'd15}, 1'b1, '{clqm_pkg::ST_OK,    1'b0, 5'd1, 4'd15}},
			'{'{clqm_pkg::ACT_APPEND, 4'd0},  1'b0, '0},
			'{'{clqm_pkg::ACT_APPEND, 4'd9},  1'b0, '0},
			'{'{clqm_pkg::ACT_APPEND, 4'd6},  1'b0, '0},
			'{'{clqm_pkg::ACT_TEST,   4'd9},  1'b0, '0},
			'{'{clqm_pkg::ACT_TEST,   4'd5},  1'b0, '0},
			'{'{clqm_pkg::ACT_REMOVE, 4'd5},  1'b1,
				'{clqm_pkg::ST_NOT_MEMBER, 1'b0, 5'd4, 4'd15}},
			'{'{ACT_NOP,              4'd10}, 1'b0, '0},
			'{'{clqm_pkg::ACT_REMOVE, 4'd15}, 1'b0, '0},
			'{'{clqm_pkg::ACT_REMOVE, 4'd9},  1'b0, '0},
			'{'{clqm_pkg::ACT_REMOVE, 4'd6},  1'b0, '0},
			'{'{clqm_pkg::ACT_APPEND, 4'd15}, 1'b0, '0},
			'{'{clqm_pkg::ACT_REMOVE, 4'd0},  1'b0, '0},
			'{'{clqm_pkg::ACT_REMOVE, 4'd15}, 1'b1, '{clqm_pkg::ST_OK,    1'b0, 5'd0, 4'd0}},
			'{'{clqm_pkg::ACT_APPEND, 4'd10}, 1'b0, '0},
			'{'{ACT_NOP,              4'd0},  1'b0, '0}
		};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int k = 0; k < NDIR; k++)
			send_item(plan[k].r, plan[k].fixed, plan[k].want);

		filling = 1'b1;
		for (int n = 0; n < NRAND; n++) begin
			if (n % 100 == 0) begin
				// hold off until the block has answered everything
				req_valid <= 1'b0;
				@(negedge clk);
				while (expect_q.size() != 0)
					@(negedge clk);
				phase = (n / 100) % 4;
				send_gap_pct = (phase == 1) ? 57 : (phase == 3) ? 22 : 0;
				stall_pct = (phase == 2) ? 57 : (phase == 3) ? 22 : 0;
			end
			if (filling && depth == clqm_pkg::ID_N && $urandom_range(3) == 0)
				filling = 1'b0;
			else if (!filling && depth == 0 && $urandom_range(2) == 0)
				filling = 1'b1;
			r = draw_item(filling);
			send_item(r, 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (expect_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/clqm_pkg.sv
rtl/core/clqm_ram.sv
rtl/core/clqm_seq.sv
rtl/core/circular_linked_queue_manager.sv
tb/tb_circular_linked_queue_manager.sv
